// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// clocked next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/peqs_pkg.sv =====
// Package for the priority event queue scheduler: sizes, codes, state type
package peqs_pkg;
  localparam int NUM_OBJECTS = 64;
  localparam int QUEUE_DEPTH = 16;
  localparam int OBJ_W = 6;
  localparam int PTR_W = 4;
  localparam int CNT_W = 5;
  localparam int CD_W = 16;
  localparam int ADDR_W = OBJ_W + PTR_W;
  localparam int EV_W = 40;
  localparam int META_W = CD_W + CNT_W + 2 * PTR_W;

  localparam logic [2:0] FN_POST_BACK  = 3'd0;
  localparam logic [2:0] FN_POST_FRONT = 3'd1;
  localparam logic [2:0] FN_DISPATCH   = 3'd2;
  localparam logic [2:0] FN_TICK       = 3'd3;
  localparam logic [2:0] FN_ARM        = 3'd4;
  localparam logic [2:0] FN_DISARM     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ARM_FAIL = 3'd2;
  localparam logic [2:0] ST_DIS_FAIL = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;

  localparam logic CFG_LIMIT   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_TREAD, S_TEXEC, S_DONE
  } state_t;
endpackage

// ===== hw/rtl/priority_event_queue_scheduler_top.sv =====
// Top level of the priority event queue scheduler
// channel | direction | handshake
// in_     | input     | start & !busy
// out_    | output    | out_valid strobe, one cycle
// cfg_    | input     | cfg_valid & cfg_ready
// Post, arm, disarm, dispatch: after accept the item passes through fetch, execute and done, then the result strobe.
// Dispatch with nothing ready skips execute: fetch, done, strobe.
// Tick: a read state and an update state per object on the per-object RAM.
// busy falls in the strobe cycle, so the next item is taken at the edge that takes the result.
// Reset is synchronous; per-object entries read as zero until written (64 valid bits).
// Results cannot be stalled.
module priority_event_queue_scheduler_top import peqs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [5:0]  in_object_index,
  input  logic [7:0]  in_signal,
  input  logic [31:0] in_param,
  input  logic [15:0] in_tick_count,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_out_object,
  output logic [7:0]  out_out_signal,
  output logic [31:0] out_out_param,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
`include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic [EV_W-1:0] mem [NUM_OBJECTS*QUEUE_DEPTH];
  logic [EV_W-1:0] rd_r;
  logic [META_W-1:0] meta_mem [NUM_OBJECTS];
  logic [META_W-1:0] meta_raw_r;
  logic meta_vq_r;
  logic [NUM_OBJECTS-1:0] meta_vld_r;
  logic [7:0] grp_r;
  logic [7:0] rows_r [8];
  logic [4:0] limit_r;
  logic [7:0] tsig_r;
  logic [2:0] fn_r;
  logic [OBJ_W-1:0] obj_r;
  logic [7:0] sig_r;
  logic [31:0] par_r;
  logic [15:0] tk_r;
  logic [2:0] st_r;
  logic [OBJ_W:0] ti_r;
  logic ov_r;
  logic [2:0] ost_r;

  logic [4:0] lim;
  logic [META_W-1:0] meta_q;
  logic [CNT_W-1:0] f, f_nxt;
  logic [PTR_W-1:0] h, t, h_nxt, t_nxt;
  logic [CD_W-1:0] cd, cd_nxt;
  logic [OBJ_W-1:0] o, ma, tobj, pick;
  logic [2:0] row, col;
  logic full, disp_ok;
  logic [4:0] tn, hn, hp;
  logic meta_we, ev_we, set_rdy, clr_rdy;
  logic [META_W-1:0] meta_wd;
  logic [ADDR_W-1:0] ev_wa;
  logic [EV_W-1:0] ev_wd;

  function automatic logic [2:0] low8(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) if (x[k]) r = 3'(k);
    return r;
  endfunction

  assign lim = (limit_r > 5'(QUEUE_DEPTH)) ? 5'(QUEUE_DEPTH) : limit_r;
  assign tobj = ti_r[OBJ_W-1:0];
  assign row = low8(grp_r);
  assign col = low8(rows_r[row]);
  assign pick = {row, col};
  assign ma = (state_r == S_TREAD) ? tobj : ((fn_r == FN_DISPATCH) ? pick : obj_r);
  assign o = (state_r == S_TEXEC) ? tobj : obj_r;
  assign meta_q = meta_vq_r ? meta_raw_r : '0;
  assign h = meta_q[PTR_W-1:0];
  assign t = meta_q[2*PTR_W-1:PTR_W];
  assign f = meta_q[2*PTR_W+CNT_W-1:2*PTR_W];
  assign cd = meta_q[META_W-1:2*PTR_W+CNT_W];
  assign full = (f >= lim);
  assign tn = ({1'b0, t} + 5'd1 >= lim) ? 5'd0 : {1'b0, t} + 5'd1;
  assign hn = ({1'b0, h} + 5'd1 >= lim) ? 5'd0 : {1'b0, h} + 5'd1;
  assign hp = (h == '0) ? lim - 5'd1 : {1'b0, h} - 5'd1;
  assign meta_wd = {cd_nxt, f_nxt, t_nxt, h_nxt};

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign disp_ok = ov_r && ost_r == ST_OK && fn_r == FN_DISPATCH;
  assign out_out_object = disp_ok ? obj_r : '0;
  assign out_out_signal = disp_ok ? rd_r[39:32] : 8'd0;
  assign out_out_param = disp_ok ? rd_r[31:0] : 32'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (fn_r == FN_TICK) state_nxt = S_TREAD;
        else if (fn_r == FN_DISPATCH && grp_r == '0) state_nxt = S_DONE;
        else state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_DONE;
      S_TREAD: state_nxt = ti_r[OBJ_W] ? S_DONE : S_TEXEC;
      S_TEXEC: state_nxt = S_TREAD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    h_nxt = h;
    t_nxt = t;
    f_nxt = f;
    cd_nxt = cd;
    meta_we = 1'b0;
    ev_we = 1'b0;
    ev_wa = {o, t};
    ev_wd = {sig_r, par_r};
    set_rdy = 1'b0;
    clr_rdy = 1'b0;
    if (state_r == S_EXEC) begin
      case (fn_r)
        FN_POST_BACK: if (!full) begin
          ev_we = 1'b1;
          t_nxt = tn[PTR_W-1:0];
          f_nxt = f + 5'd1;
          meta_we = 1'b1;
          set_rdy = 1'b1;
        end
        FN_POST_FRONT: if (!full) begin
          ev_we = 1'b1;
          ev_wa = {o, hp[PTR_W-1:0]};
          h_nxt = hp[PTR_W-1:0];
          f_nxt = f + 5'd1;
          meta_we = 1'b1;
          set_rdy = 1'b1;
        end
        FN_DISPATCH: begin
          h_nxt = hn[PTR_W-1:0];
          f_nxt = f - 5'd1;
          meta_we = 1'b1;
          clr_rdy = (f == 5'd1);
        end
        FN_ARM: if (tk_r != '0 && cd == '0) begin
          cd_nxt = tk_r;
          meta_we = 1'b1;
        end
        FN_DISARM: if (cd != '0) begin
          cd_nxt = '0;
          meta_we = 1'b1;
        end
        default: ;
      endcase
    end else if (state_r == S_TEXEC && cd != '0) begin
      cd_nxt = cd - 16'd1;
      meta_we = 1'b1;
      if (cd == 16'd1 && !full) begin
        ev_we = 1'b1;
        ev_wd = {tsig_r, 32'd0};
        t_nxt = tn[PTR_W-1:0];
        f_nxt = f + 5'd1;
        set_rdy = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && fn_r == FN_DISPATCH) begin
      rd_r <= mem[{o, h}];
    end
    if (ev_we) begin
      mem[ev_wa] <= ev_wd;
    end
    if (state_r == S_FETCH || state_r == S_TREAD) begin
      meta_raw_r <= meta_mem[ma];
      meta_vq_r <= meta_vld_r[ma];
    end
    if (meta_we) begin
      meta_mem[o] <= meta_wd;
    end
    if (start && !busy) begin
      fn_r <= in_func;
      obj_r <= in_object_index;
      sig_r <= in_signal;
      par_r <= in_param;
      tk_r <= in_tick_count;
    end else if (state_r == S_FETCH && fn_r == FN_DISPATCH) begin
      obj_r <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r <= '0;
      for (int k = 0; k < 8; k++) rows_r[k] <= '0;
      grp_r <= '0;
      limit_r <= 5'd16;
      tsig_r <= 8'd4;
      ov_r <= 1'b0;
      ost_r <= ST_OK;
      st_r <= ST_OK;
      ti_r <= '0;
    end else begin
      ov_r <= (state_r == S_DONE);
      if (state_r == S_DONE) begin
        ost_r <= st_r;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LIMIT) limit_r <= cfg_data[4:0];
        else tsig_r <= cfg_data;
      end
      if (state_r == S_IDLE) begin
        st_r <= ST_OK;
        ti_r <= '0;
      end
      if (state_r == S_FETCH && fn_r == FN_DISPATCH && grp_r == '0) begin
        st_r <= ST_NONE;
      end
      if (state_r == S_EXEC) begin
        case (fn_r)
          FN_POST_BACK, FN_POST_FRONT: if (full) st_r <= ST_FULL;
          FN_ARM: if (tk_r == '0 || cd != '0) st_r <= ST_ARM_FAIL;
          FN_DISARM: if (cd == '0) st_r <= ST_DIS_FAIL;
          default: ;
        endcase
      end
      if (state_r == S_TEXEC) begin
        ti_r <= ti_r + 1'b1;
      end
      if (meta_we) begin
        meta_vld_r[o] <= 1'b1;
      end
      if (set_rdy) begin
        grp_r[o[5:3]] <= 1'b1;
        rows_r[o[5:3]][o[2:0]] <= 1'b1;
      end
      if (clr_rdy) begin
        rows_r[o[5:3]][o[2:0]] <= 1'b0;
        if ((rows_r[o[5:3]] & ~(8'd1 << o[2:0])) == '0) grp_r[o[5:3]] <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_done_strobe, clk, rst_n, state_r == S_DONE, out_valid)
  `ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, state_r == S_IDLE)
  `ASSERT_IMP(a_grp_rows, clk, rst_n, state_r == S_IDLE,
    (grp_r == '0) == ((rows_r[0] | rows_r[1] | rows_r[2] | rows_r[3] |
    rows_r[4] | rows_r[5] | rows_r[6] | rows_r[7]) == '0))
endmodule
